### hw/rtl/mtp_pkg.sv
// ----------------------------------------------------------------------------
// Meter telegram parser package
// Character codes, event and field tags, field limits and phase type.
// ----------------------------------------------------------------------------
package mtp_pkg;

	// Field limits
	localparam logic [5:0] VENDOR_LEN = 6'd3;
	localparam logic [5:0] IDENT_MAX  = 6'd16;
	localparam logic [5:0] OBIS_MAX   = 6'd16;
	localparam logic [5:0] VALUE_MAX  = 6'd32;
	localparam logic [5:0] UNIT_MAX   = 6'd16;

	// Line breaks that close the ident block and a data line
	localparam logic [2:0] IDENT_BREAKS = 3'd4;
	localparam logic [2:0] LINE_BREAKS  = 3'd2;

	// Characters
	localparam logic [7:0] CH_SLASH = 8'h2F;
	localparam logic [7:0] CH_BANG  = 8'h21;
	localparam logic [7:0] CH_LPAR  = 8'h28;
	localparam logic [7:0] CH_RPAR  = 8'h29;
	localparam logic [7:0] CH_STAR  = 8'h2A;
	localparam logic [7:0] CH_CR    = 8'h0D;
	localparam logic [7:0] CH_LF    = 8'h0A;

	// Event codes
	localparam logic [2:0] EV_CHAR   = 3'd0;
	localparam logic [2:0] EV_FEND   = 3'd1;
	localparam logic [2:0] EV_RECORD = 3'd2;
	localparam logic [2:0] EV_TEND   = 3'd3;
	localparam logic [2:0] EV_ERROR  = 3'd4;

	// Field tags
	localparam logic [2:0] TAG_VENDOR = 3'd0;
	localparam logic [2:0] TAG_BAUD   = 3'd1;
	localparam logic [2:0] TAG_IDENT  = 3'd2;
	localparam logic [2:0] TAG_OBIS   = 3'd3;
	localparam logic [2:0] TAG_VALUE  = 3'd4;
	localparam logic [2:0] TAG_UNIT   = 3'd5;

	localparam logic [7:0] MAX_RECORDS_RST = 8'd32;

	typedef enum logic [8:0] {
		PH_IDLE    = 9'b000000001,
		PH_VENDOR  = 9'b000000010,
		PH_BAUD    = 9'b000000100,
		PH_IDENT   = 9'b000001000,
		PH_OBIS    = 9'b000010000,
		PH_VALUE   = 9'b000100000,
		PH_UNIT    = 9'b001000000,
		PH_ENDLINE = 9'b010000000,
		PH_ERROR   = 9'b100000000
	} phase_t;

endpackage

### hw/rtl/meter_telegram_parser.sv
// Pipeline: an accepted byte is parsed from the input register in a single pass
// of small logic, and its result (if any) is registered in the result register.
// Throughput: one byte per cycle unless a held output backs up both stages.
// Reset (arst_n low, async): phase idle, counters and flags cleared,
// max_records back to 32, both stages empty.
// ----------------------------------------------------------------------------
// Meter telegram parser
// Splits a plain-text meter readout telegram, one byte per request, into
// tagged field characters, field ends, record-done, telegram-end and error events.
// ----------------------------------------------------------------------------
module meter_telegram_parser (
	input  logic       clk,
	input  logic       arst_n,
	// configuration
	input  logic       cfg_we,
	input  logic [7:0] cfg_wdata,
	// byte input
	input  logic       in_valid,
	output logic       in_stall,
	input  logic [7:0] data_byte,
	// event output
	output logic       out_valid,
	input  logic       out_stall,
	output logic [2:0] event_res,
	output logic [2:0] field_tag,
	output logic [7:0] char_out,
	output logic       field_last,
	output logic       overflow,
	output logic [7:0] record_count
);

	// ------------------------------------------------------------------
	// Registers
	// ------------------------------------------------------------------
	logic [7:0]      max_records_q;

	// input stage
	logic            valid_s1;
	logic [7:0]      data_s1;

	// parser state
	mtp_pkg::phase_t phase_q;
	logic [5:0]      pos_q;
	logic [2:0]      lbc_q;
	logic [7:0]      rec_q;
	logic            ovf_q;

	// result stage
	logic            valid_s2;
	logic [2:0]      ev_s2;
	logic [2:0]      tag_s2;
	logic [7:0]      ch_s2;
	logic            last_s2;
	logic            ovf_s2;
	logic [7:0]      rec_s2;

	// The result stage can take a new value when it is empty or being drained.
	// The input stage moves whenever the result stage does, so a full result
	// register with a held output does not stop bytes until stage 1 fills.
	logic advance;
	logic in_fire;

	assign advance  = !valid_s2 || !out_stall;
	assign in_stall = valid_s1 && !advance;
	assign in_fire  = in_valid && !in_stall;

	// ------------------------------------------------------------------
	// Parse logic: next state and result for the byte in stage 1
	// ------------------------------------------------------------------
	mtp_pkg::phase_t phase_d;
	logic [5:0]      pos_d;
	logic [2:0]      lbc_d;
	logic [7:0]      rec_d;
	logic            ovf_d;
	logic            res_v;
	logic [2:0]      ev_d;
	logic [2:0]      tag_d;
	logic [7:0]      ch_d;
	logic            last_d;

	logic            brk;
	logic            letter;
	logic [5:0]      pos_inc;
	logic [2:0]      lbc_inc;
	// shared path for length-limited field characters
	logic            fc_req;
	logic [2:0]      fc_tag;
	logic [5:0]      fc_lim;

	assign brk     = (data_s1 == mtp_pkg::CH_CR) || (data_s1 == mtp_pkg::CH_LF);
	assign pos_inc = pos_q + 6'd1;
	assign lbc_inc = lbc_q + 3'd1;

	always_comb begin
		letter = data_s1 inside {[8'h41:8'h5A], [8'h61:8'h7A]};
	end

	always_comb begin
		phase_d = phase_q;
		pos_d   = pos_q;
		lbc_d   = lbc_q;
		rec_d   = rec_q;
		ovf_d   = ovf_q;
		res_v   = 1'b0;
		ev_d    = mtp_pkg::EV_CHAR;
		tag_d   = mtp_pkg::TAG_VENDOR;
		ch_d    = 8'd0;
		last_d  = 1'b0;
		fc_req  = 1'b0;
		fc_tag  = mtp_pkg::TAG_IDENT;
		fc_lim  = mtp_pkg::IDENT_MAX;

		if (data_s1 == mtp_pkg::CH_SLASH) begin
			// restart from any phase, silently
			phase_d = mtp_pkg::PH_VENDOR;
			pos_d   = 6'd0;
			lbc_d   = 3'd0;
			rec_d   = 8'd0;
			ovf_d   = 1'b0;
		end else if (phase_q == mtp_pkg::PH_IDLE || phase_q == mtp_pkg::PH_ERROR) begin
			// wait for a start mark
		end else if (data_s1 == mtp_pkg::CH_BANG) begin
			phase_d = mtp_pkg::PH_IDLE;
			res_v   = 1'b1;
			ev_d    = mtp_pkg::EV_TEND;
		end else begin
			case (phase_q)
				mtp_pkg::PH_VENDOR: begin
					res_v = 1'b1;
					if (!letter) begin
						phase_d = mtp_pkg::PH_ERROR;
						ev_d    = mtp_pkg::EV_ERROR;
					end else if (pos_inc >= mtp_pkg::VENDOR_LEN) begin
						pos_d   = 6'd0;
						lbc_d   = 3'd0;
						phase_d = mtp_pkg::PH_BAUD;
						ch_d    = data_s1;
						last_d  = 1'b1;
					end else begin
						pos_d = pos_inc;
						ch_d  = data_s1;
					end
				end
				mtp_pkg::PH_BAUD: begin
					pos_d   = 6'd0;
					lbc_d   = 3'd0;
					phase_d = mtp_pkg::PH_IDENT;
					res_v   = 1'b1;
					tag_d   = mtp_pkg::TAG_BAUD;
					ch_d    = data_s1;
					last_d  = 1'b1;
				end
				mtp_pkg::PH_IDENT: begin
					if (brk) begin
						// breaks count over the whole ident block
						if (lbc_inc >= mtp_pkg::IDENT_BREAKS) begin
							pos_d   = 6'd0;
							lbc_d   = 3'd0;
							phase_d = mtp_pkg::PH_OBIS;
							res_v   = 1'b1;
							ev_d    = mtp_pkg::EV_FEND;
							tag_d   = mtp_pkg::TAG_IDENT;
						end else begin
							lbc_d = lbc_inc;
						end
					end else begin
						fc_req = 1'b1;
						fc_tag = mtp_pkg::TAG_IDENT;
						fc_lim = mtp_pkg::IDENT_MAX;
					end
				end
				mtp_pkg::PH_OBIS: begin
					if (data_s1 == mtp_pkg::CH_LPAR) begin
						pos_d   = 6'd0;
						lbc_d   = 3'd0;
						phase_d = mtp_pkg::PH_VALUE;
						res_v   = 1'b1;
						ev_d    = mtp_pkg::EV_FEND;
						tag_d   = mtp_pkg::TAG_OBIS;
					end else begin
						fc_req = 1'b1;
						fc_tag = mtp_pkg::TAG_OBIS;
						fc_lim = mtp_pkg::OBIS_MAX;
					end
				end
				mtp_pkg::PH_VALUE: begin
					if (data_s1 == mtp_pkg::CH_STAR || data_s1 == mtp_pkg::CH_RPAR) begin
						pos_d   = 6'd0;
						lbc_d   = 3'd0;
						phase_d = (data_s1 == mtp_pkg::CH_RPAR) ? mtp_pkg::PH_ENDLINE
						                                         : mtp_pkg::PH_UNIT;
						res_v   = 1'b1;
						ev_d    = mtp_pkg::EV_FEND;
						tag_d   = mtp_pkg::TAG_VALUE;
					end else begin
						fc_req = 1'b1;
						fc_tag = mtp_pkg::TAG_VALUE;
						fc_lim = mtp_pkg::VALUE_MAX;
					end
				end
				mtp_pkg::PH_UNIT: begin
					if (data_s1 == mtp_pkg::CH_RPAR) begin
						pos_d   = 6'd0;
						lbc_d   = 3'd0;
						phase_d = mtp_pkg::PH_ENDLINE;
						res_v   = 1'b1;
						ev_d    = mtp_pkg::EV_FEND;
						tag_d   = mtp_pkg::TAG_UNIT;
					end else begin
						fc_req = 1'b1;
						fc_tag = mtp_pkg::TAG_UNIT;
						fc_lim = mtp_pkg::UNIT_MAX;
					end
				end
				mtp_pkg::PH_ENDLINE: begin
					// anything but a line break is skipped here
					if (brk) begin
						if (lbc_inc >= mtp_pkg::LINE_BREAKS) begin
							if (rec_q < max_records_q) begin
								rec_d = rec_q + 8'd1;
							end
							pos_d   = 6'd0;
							lbc_d   = 3'd0;
							phase_d = mtp_pkg::PH_OBIS;
							res_v   = 1'b1;
							ev_d    = mtp_pkg::EV_RECORD;
						end else begin
							lbc_d = lbc_inc;
						end
					end
				end
				default: begin
					phase_d = mtp_pkg::PH_IDLE;
				end
			endcase

			if (fc_req) begin
				if (pos_q < fc_lim) begin
					pos_d = pos_inc;
					res_v = 1'b1;
					tag_d = fc_tag;
					ch_d  = data_s1;
				end else begin
					// past the field limit: drop and flag
					ovf_d = 1'b1;
				end
			end
		end
	end

	// ------------------------------------------------------------------
	// Configuration register
	// ------------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_records_q <= mtp_pkg::MAX_RECORDS_RST;
		end else if (cfg_we) begin
			max_records_q <= cfg_wdata;
		end
	end

	// ------------------------------------------------------------------
	// Input stage
	// ------------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (advance || !valid_s1) begin
			valid_s1 <= in_fire;
		end
	end

	always_ff @(posedge clk) begin
		if (in_fire) begin
			data_s1 <= data_byte;
		end
	end

	// ------------------------------------------------------------------
	// Parser state: updated as the byte leaves stage 1
	// ------------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= mtp_pkg::PH_IDLE;
			pos_q   <= 6'd0;
			lbc_q   <= 3'd0;
			rec_q   <= 8'd0;
			ovf_q   <= 1'b0;
		end else if (valid_s1 && advance) begin
			phase_q <= phase_d;
			pos_q   <= pos_d;
			lbc_q   <= lbc_d;
			rec_q   <= rec_d;
			ovf_q   <= ovf_d;
		end
	end

	// ------------------------------------------------------------------
	// Result stage
	// ------------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (advance) begin
			valid_s2 <= valid_s1 && res_v;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && valid_s1 && res_v) begin
			ev_s2   <= ev_d;
			tag_s2  <= tag_d;
			ch_s2   <= ch_d;
			last_s2 <= last_d;
			ovf_s2  <= ovf_d;
			rec_s2  <= rec_d;
		end
	end

	assign out_valid    = valid_s2;
	assign event_res    = ev_s2;
	assign field_tag    = tag_s2;
	assign char_out     = ch_s2;
	assign field_last   = last_s2;
	assign overflow     = ovf_s2;
	assign record_count = rec_s2;

	// ------------------------------------------------------------------
	// Assertions
	// ------------------------------------------------------------------
	// only field-character events carry a character
	a_char_only_on_char: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s2 && (ev_s2 != mtp_pkg::EV_CHAR) |-> (ch_s2 == 8'd0))
		else $error("character on a non-character event");

	// field_last only for the vendor and baud characters
	a_last_fixed_fields: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s2 && last_s2 |-> (ev_s2 == mtp_pkg::EV_CHAR) &&
		((tag_s2 == mtp_pkg::TAG_VENDOR) || (tag_s2 == mtp_pkg::TAG_BAUD)))
		else $error("field_last on an unexpected event");

	// record, telegram end and error events carry tag zero
	a_tag_zero: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s2 && ((ev_s2 == mtp_pkg::EV_RECORD) || (ev_s2 == mtp_pkg::EV_TEND) ||
		(ev_s2 == mtp_pkg::EV_ERROR)) |-> (tag_s2 == mtp_pkg::TAG_VENDOR))
		else $error("nonzero tag on a non-field event");

	// a parsed byte with no result frees the result register when drained
	a_no_phantom: assert property (@(posedge clk) disable iff (!arst_n)
		advance && !(valid_s1 && res_v) |=> !valid_s2)
		else $error("result appeared without a producing byte");

endmodule
